### src/jsr_pkg.sv
// Package for the JSON stream reindenter: sequencer states, character codes,
// register indexes, field widths and reset values. No dependencies.
package jsr_pkg;

	localparam int BYTE_W      = 8;
	localparam int REPEAT_W    = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int DEPTH_W     = 5;
	localparam int COUNT_W     = 6;
	localparam int FLAGS_W     = 3;

	localparam int MAX_DEPTH_DEFAULT = 15;

	localparam logic [CFG_INDEX_W-1:0] CFG_INDENT_CHAR   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INDENT_REPEAT = 1'd1;

	localparam logic [BYTE_W-1:0]   INDENT_CHAR_RESET   = 8'h09;
	localparam logic [REPEAT_W-1:0] INDENT_REPEAT_RESET = 3'd1;
	localparam logic [REPEAT_W-1:0] REPEAT_LIMIT        = 3'd4;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_SEMI      = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
	localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_NONE      = 8'h00;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

### src/json_stream_reindenter.sv
// Top level of the JSON stream reindenter: input decode, nesting state and an
// output sequencer that emits each transaction's bytes one per unstalled cycle.
// Depends on jsr_pkg.
//
//   channel   direction   tdata            tuser / tlast
//   s_*       in          in_byte          tuser: kind
//   m_*       out         out_byte         tlast: last, tuser: flags
//   cfg_*     in          register value   cfg_index selects the register
//
// An input transaction is taken while the sequencer is idle; its results then
// leave at one per cycle through the output register; an item with N results
// (N is 0 to 62) holds s_tready low until the last is loaded. The indent
// run is counted down by one shared counter. A stalled m_tready holds the
// sequencer. Reset clears the nesting state and restores both registers.
module json_stream_reindenter #(
	parameter int MAX_DEPTH = jsr_pkg::MAX_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [jsr_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] in_byte
	input  logic                            s_tuser,   // [0] kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [jsr_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
	output logic                            m_tlast,
	output logic [jsr_pkg::FLAGS_W-1:0]     m_tuser,   // [0] underflow,
	                                                   // [1] depth_saturated,
	                                                   // [2] unbalanced_end
	input  logic                            cfg_we,
	input  logic [jsr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [jsr_pkg::BYTE_W-1:0]      cfg_data
);

	import jsr_pkg::*;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -DEPTH_W'(MAX_DEPTH);

	state_t state_q, state_d;

	logic [BYTE_W-1:0]          indent_char_q;
	logic [REPEAT_W-1:0]        indent_repeat_q;
	logic                       escape_q, escape_d;
	logic [BYTE_W-1:0]          quote_q, quote_d;
	logic signed [DEPTH_W-1:0]  depth_q, depth_d;

	logic                       head_q, head_d;
	logic                       nl_q, nl_d;
	logic                       tail_q, tail_d;
	logic [COUNT_W-1:0]         count_q, count_d;
	logic [BYTE_W-1:0]          byte_q;
	logic [FLAGS_W-1:0]         flags_q, flags_d;

	logic                       out_valid_q;
	logic [BYTE_W-1:0]          out_byte_q;
	logic                       out_last_q;
	logic [FLAGS_W-1:0]         out_flags_q;

	logic                       accept;
	logic                       out_free;
	logic                       load;
	logic [BYTE_W-1:0]          load_byte;
	logic                       load_last;
	logic [REPEAT_W-1:0]        rep_eff;
	logic signed [DEPTH_W-1:0]  ind_depth;
	logic [DEPTH_W+REPEAT_W-1:0] ind_product;
	logic                       want_ind;
	logic                       uf, sat, unb;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign rep_eff  = (indent_repeat_q > REPEAT_LIMIT) ? REPEAT_LIMIT : indent_repeat_q;
	assign ind_product = (ind_depth > 0)
		? ({{(REPEAT_W){1'b0}}, ind_depth} * {{(DEPTH_W){1'b0}}, rep_eff})
		: '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		escape_d  = escape_q;
		quote_d   = quote_q;
		depth_d   = depth_q;
		head_d    = head_q;
		nl_d      = nl_q;
		tail_d    = tail_q;
		count_d   = count_q;
		flags_d   = flags_q;
		uf        = 1'b0;
		sat       = 1'b0;
		unb       = 1'b0;
		want_ind  = 1'b0;
		ind_depth = depth_q;
		load      = 1'b0;
		load_byte = byte_q;
		load_last = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					head_d = 1'b0;
					nl_d   = 1'b0;
					tail_d = 1'b0;
					if (s_tuser == KIND_END) begin
						unb      = (depth_q != 0) || (quote_q != CH_NONE);
						nl_d     = 1'b1;
						escape_d = 1'b0;
						quote_d  = CH_NONE;
						depth_d  = '0;
					end else if (escape_q) begin
						head_d   = 1'b1;
						escape_d = 1'b0;
					end else begin
						case (s_tdata) inside
							CH_BACKSLASH: begin
								escape_d = 1'b1;
								head_d   = 1'b1;
							end
							CH_COMMA, CH_SEMI: begin
								head_d = 1'b1;
								if (quote_q == CH_NONE) begin
									nl_d     = 1'b1;
									want_ind = 1'b1;
								end
							end
							CH_DQUOTE, CH_SQUOTE: begin
								head_d = 1'b1;
								if (quote_q == CH_NONE) begin
									quote_d = s_tdata;
								end else if (quote_q == s_tdata) begin
									quote_d = CH_NONE;
								end
							end
							CH_LBRACE, CH_LBRACKET: begin
								head_d = 1'b1;
								if (quote_q == CH_NONE) begin
									if (depth_q >= DEPTH_MAX) begin
										sat = 1'b1;
									end else begin
										depth_d = depth_q + 1'b1;
									end
									nl_d      = 1'b1;
									want_ind  = 1'b1;
									ind_depth = depth_d;
								end
							end
							CH_RBRACE, CH_RBRACKET: begin
								if (quote_q == CH_NONE) begin
									if (depth_q <= DEPTH_MIN) begin
										sat = 1'b1;
									end else begin
										depth_d = depth_q - 1'b1;
									end
									uf        = (depth_d < 0);
									nl_d      = 1'b1;
									want_ind  = 1'b1;
									ind_depth = depth_d;
									tail_d    = 1'b1;
								end else begin
									head_d = 1'b1;
								end
							end
							CH_LF, CH_CR: begin
								head_d = (quote_q != CH_NONE);
							end
							default: begin
								head_d = 1'b1;
							end
						endcase
					end
					count_d = want_ind ? ind_product[COUNT_W-1:0] : '0;
					flags_d = {unb, sat, uf};
					if (head_d || nl_d || tail_d) begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (out_free) begin
					load = 1'b1;
					if (head_q) begin
						head_d    = 1'b0;
						load_byte = byte_q;
					end else if (nl_q) begin
						nl_d      = 1'b0;
						load_byte = CH_LF;
					end else if (count_q != 0) begin
						count_d   = count_q - 1'b1;
						load_byte = indent_char_q;
					end else begin
						tail_d    = 1'b0;
						load_byte = byte_q;
					end
					load_last = !(head_d || nl_d || tail_d || (count_d != 0));
					if (load_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indent_char_q   <= INDENT_CHAR_RESET;
			indent_repeat_q <= INDENT_REPEAT_RESET;
			escape_q        <= 1'b0;
			quote_q         <= CH_NONE;
			depth_q         <= '0;
			head_q          <= 1'b0;
			nl_q            <= 1'b0;
			tail_q          <= 1'b0;
			count_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INDENT_CHAR:   indent_char_q   <= cfg_data;
					CFG_INDENT_REPEAT: indent_repeat_q <= cfg_data[REPEAT_W-1:0];
					default: ;
				endcase
			end
			escape_q <= escape_d;
			quote_q  <= quote_d;
			depth_q  <= depth_d;
			head_q   <= head_d;
			nl_q     <= nl_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= s_tdata;
		end
		flags_q <= flags_d;
		if (load) begin
			out_byte_q  <= load_byte;
			out_last_q  <= load_last;
			out_flags_q <= flags_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_flags_q;

endmodule
